// ===== hw/rtl/blcm_pkg.sv =====
// ----------------------------------------------------------------------------
// Battery monitor package
// Shared constants, types and helper functions for the battery level and
// charge monitor.
// ----------------------------------------------------------------------------
package blcm_pkg;

   localparam int MV_BITS   = 13;
   localparam int PCT_BITS  = 7;
   localparam int LED_BITS  = 3;
   localparam int MS_BITS   = 32;
   localparam int IVL_BITS  = 16;
   localparam int CSR_IDX_BITS  = 3;
   localparam int CSR_DATA_BITS = 16;

   localparam logic [MV_BITS-1:0] FULL_SCALE_MV = 13'd4200;
   localparam logic [MV_BITS-1:0] EMPTY_MV      = 13'd3300;

   // Division by the 900 mV span times 100 is a division by 9 on the
   // offset above empty, done as a reciprocal multiply and shift.
   localparam int SPAN_OFS_BITS = 10;
   localparam int RECIP_BITS    = 13;
   localparam int RECIP_SHIFT   = 16;
   localparam logic [RECIP_BITS-1:0] RECIP_NINTH = 13'd7282;

   localparam logic [PCT_BITS-1:0] LEVEL_HIGH = 7'd75;
   localparam logic [PCT_BITS-1:0] LEVEL_MID  = 7'd50;
   localparam logic [PCT_BITS-1:0] LEVEL_LOW  = 7'd25;

   localparam logic [LED_BITS-1:0] LED_NONE     = 3'd0;
   localparam logic [LED_BITS-1:0] LED_LVL_HIGH = 3'd1;
   localparam logic [LED_BITS-1:0] LED_LVL_MID  = 3'd2;
   localparam logic [LED_BITS-1:0] LED_LVL_LOW  = 3'd3;
   localparam logic [LED_BITS-1:0] LED_RED      = 3'd4;
   localparam logic [LED_BITS-1:0] LED_FULL     = 3'd5;

   localparam logic [CSR_IDX_BITS-1:0] CSR_CRITICAL_PERCENT = 3'd0;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHARGE_DELTA_MV  = 3'd1;
   localparam logic [CSR_IDX_BITS-1:0] CSR_FULL_CHARGE_MV   = 3'd2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_CHECK_INTERVAL   = 3'd3;
   localparam logic [CSR_IDX_BITS-1:0] CSR_POWER_ON_WINDOW  = 3'd4;

   localparam logic [PCT_BITS-1:0] RST_CRITICAL_PERCENT = 7'd15;
   localparam logic [MV_BITS-1:0]  RST_CHARGE_DELTA_MV  = 13'd50;
   localparam logic [MV_BITS-1:0]  RST_FULL_CHARGE_MV   = 13'd4190;
   localparam logic [IVL_BITS-1:0] RST_CHECK_INTERVAL   = 16'd1000;
   localparam logic [IVL_BITS-1:0] RST_POWER_ON_WINDOW  = 16'd5000;

   typedef struct packed {
      logic load;
      logic scale;
      logic level;
      logic update;
   } blcm_cmd_type;

   function automatic logic [LED_BITS-1:0] level_color(input logic [PCT_BITS-1:0] pct);
      logic [LED_BITS-1:0] color;
      if (pct > LEVEL_HIGH) begin
         color = LED_LVL_HIGH;
      end else if (pct > LEVEL_MID) begin
         color = LED_LVL_MID;
      end else if (pct > LEVEL_LOW) begin
         color = LED_LVL_LOW;
      end else begin
         color = LED_RED;
      end
      return color;
   endfunction

endpackage

// ===== hw/rtl/blcm_if.sv =====
// ----------------------------------------------------------------------------
// Battery monitor channels
// Valid/ready interfaces for the sample channel and the result channel.
// ----------------------------------------------------------------------------
interface blcm_req_if #(parameter int ADC_BITS = 12);
   logic                valid;
   logic                ready;
   logic [ADC_BITS-1:0] adc_code;
   logic [31:0]         now_ms;

   modport source (output valid, adc_code, now_ms, input ready);
   modport sink (input valid, adc_code, now_ms, output ready);
endinterface

interface blcm_rsp_if;
   logic        valid;
   logic        ready;
   logic [6:0]  battery_percent;
   logic [12:0] sample_mv;
   logic [2:0]  led_code;
   logic        charging;
   logic        charging_started;
   logic        full_charge;
   logic        warning_active;
   logic        warning_started;
   logic [12:0] peak_mv;

   modport source (output valid, battery_percent, sample_mv, led_code, charging,
                   charging_started, full_charge, warning_active, warning_started,
                   peak_mv, input ready);
   modport sink (input valid, battery_percent, sample_mv, led_code, charging,
                 charging_started, full_charge, warning_active, warning_started,
                 peak_mv, output ready);
endinterface

// ===== hw/rtl/battery_level_charge_monitor.sv =====
// ----------------------------------------------------------------------------
// Battery level and charge monitor
// Scales converter samples to millivolts and percent, requests a level color
// after power-on, detects charging and full charge, and latches a warning.
// ----------------------------------------------------------------------------
// After an item is accepted, the millivolt multiply, the percent multiply
// and the state update are done in turn, and the result then becomes valid.
// The result stays valid until it is taken, and a new item is accepted no
// earlier than the cycle after that, so a new item is not taken before the
// result of the last one has been taken. The five configuration
// registers may be written at any time the block is idle and take effect on
// the next item.
module battery_level_charge_monitor
   import blcm_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   blcm_req_if.sink                 req_ch,
   blcm_rsp_if.source               rsp_ch,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata
);

   blcm_cmd_type cmd;

   blcm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .rsp_valid (rsp_ch.valid),
      .rsp_ready (rsp_ch.ready),
      .cmd       (cmd)
   );

   blcm_datapath #(
      .ADC_BITS (ADC_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .csr_we           (csr_we),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .adc_code         (req_ch.adc_code),
      .now_ms           (req_ch.now_ms),
      .battery_percent  (rsp_ch.battery_percent),
      .sample_mv        (rsp_ch.sample_mv),
      .led_code         (rsp_ch.led_code),
      .charging         (rsp_ch.charging),
      .charging_started (rsp_ch.charging_started),
      .full_charge      (rsp_ch.full_charge),
      .warning_active   (rsp_ch.warning_active),
      .warning_started  (rsp_ch.warning_started),
      .peak_mv          (rsp_ch.peak_mv)
   );

endmodule

// ===== hw/rtl/blcm_ctrl.sv =====
// ----------------------------------------------------------------------------
// Battery monitor controller
// Sequences one item through scaling, level and state update, then holds
// the result until it is taken.
// ----------------------------------------------------------------------------
module blcm_ctrl
   import blcm_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output blcm_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCALE,
      ST_LEVEL,
      ST_UPDATE,
      ST_DONE
   } state_type;

   state_type state_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  state_ff <= ST_SCALE;
               end
            end
            ST_SCALE:  state_ff <= ST_LEVEL;
            ST_LEVEL:  state_ff <= ST_UPDATE;
            ST_UPDATE: state_ff <= ST_DONE;
            ST_DONE: begin
               if (rsp_ready) begin
                  state_ff <= ST_IDLE;
               end
            end
            default:   state_ff <= ST_IDLE;
         endcase
      end
   end

   assign req_ready  = (state_ff == ST_IDLE);
   assign rsp_valid  = (state_ff == ST_DONE);
   assign cmd.load   = req_ready & req_valid;
   assign cmd.scale  = (state_ff == ST_SCALE);
   assign cmd.level  = (state_ff == ST_LEVEL);
   assign cmd.update = (state_ff == ST_UPDATE);

endmodule

// ===== hw/rtl/blcm_datapath.sv =====
// ----------------------------------------------------------------------------
// Battery monitor datapath
// Configuration registers, sample scaling, check timing and the charge and
// warning latches.
// ----------------------------------------------------------------------------
module blcm_datapath
   import blcm_pkg::*;
#(
   parameter int ADC_BITS = 12
) (
   input  logic                     clock,
   input  logic                     reset,
   input  blcm_cmd_type             cmd,
   input  logic                     csr_we,
   input  logic [CSR_IDX_BITS-1:0]  csr_index,
   input  logic [CSR_DATA_BITS-1:0] csr_wdata,
   input  logic [ADC_BITS-1:0]      adc_code,
   input  logic [MS_BITS-1:0]       now_ms,
   output logic [PCT_BITS-1:0]      battery_percent,
   output logic [MV_BITS-1:0]       sample_mv,
   output logic [LED_BITS-1:0]      led_code,
   output logic                     charging,
   output logic                     charging_started,
   output logic                     full_charge,
   output logic                     warning_active,
   output logic                     warning_started,
   output logic [MV_BITS-1:0]       peak_mv
);

   localparam int PROD_BITS = ADC_BITS + MV_BITS;
   localparam int PCT_PROD_BITS = SPAN_OFS_BITS + RECIP_BITS;

   logic [PCT_BITS-1:0] critical_ff;
   logic [MV_BITS-1:0]  delta_thr_ff;
   logic [MV_BITS-1:0]  full_mv_ff;
   logic [IVL_BITS-1:0] interval_ff;
   logic [IVL_BITS-1:0] window_ff;

   logic [ADC_BITS-1:0] code_ff;
   logic [MS_BITS-1:0]  now_ff;
   logic [MV_BITS-1:0]  mv_ff;
   logic [PCT_BITS-1:0] pct_ff;

   logic                charging_ff;
   logic                charging_in;
   logic                warning_ff;
   logic                warning_in;
   logic [MS_BITS-1:0]  last_ms_ff;
   logic [MV_BITS-1:0]  last_mv_ff;
   logic [MV_BITS-1:0]  peak_ff;
   logic [MV_BITS-1:0]  peak_in;

   logic [LED_BITS-1:0] led_ff;
   logic [LED_BITS-1:0] led_in;
   logic                started_ff;
   logic                started_in;
   logic                full_ff;
   logic                full_in;
   logic                warn_start_ff;
   logic                warn_start_in;

   logic [PROD_BITS-1:0]     mv_prod;
   logic [MV_BITS-1:0]       span_ofs;
   logic [PCT_PROD_BITS-1:0] pct_prod;
   logic [MS_BITS-1:0]       elapsed;
   logic                     check_due;
   logic signed [MV_BITS:0]  rise;

   always_ff @(posedge clock) begin
      if (reset) begin
         critical_ff  <= RST_CRITICAL_PERCENT;
         delta_thr_ff <= RST_CHARGE_DELTA_MV;
         full_mv_ff   <= RST_FULL_CHARGE_MV;
         interval_ff  <= RST_CHECK_INTERVAL;
         window_ff    <= RST_POWER_ON_WINDOW;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CRITICAL_PERCENT: critical_ff  <= csr_wdata[PCT_BITS-1:0];
            CSR_CHARGE_DELTA_MV:  delta_thr_ff <= csr_wdata[MV_BITS-1:0];
            CSR_FULL_CHARGE_MV:   full_mv_ff   <= csr_wdata[MV_BITS-1:0];
            CSR_CHECK_INTERVAL:   interval_ff  <= csr_wdata[IVL_BITS-1:0];
            CSR_POWER_ON_WINDOW:  window_ff    <= csr_wdata[IVL_BITS-1:0];
            default: ;
         endcase
      end
   end

   assign mv_prod  = {{MV_BITS{1'b0}}, code_ff} * {{ADC_BITS{1'b0}}, FULL_SCALE_MV};
   assign span_ofs = mv_ff - EMPTY_MV;
   assign pct_prod = {{RECIP_BITS{1'b0}}, span_ofs[SPAN_OFS_BITS-1:0]}
                   * {{SPAN_OFS_BITS{1'b0}}, RECIP_NINTH};

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         code_ff <= adc_code;
         now_ff  <= now_ms;
      end
      if (cmd.scale) begin
         mv_ff <= mv_prod[ADC_BITS +: MV_BITS];
      end
      if (cmd.level) begin
         if (mv_ff <= EMPTY_MV) begin
            pct_ff <= '0;
         end else begin
            pct_ff <= pct_prod[RECIP_SHIFT +: PCT_BITS];
         end
      end
   end

   assign elapsed   = now_ff - last_ms_ff;
   assign check_due = (elapsed >= {{(MS_BITS-IVL_BITS){1'b0}}, interval_ff});
   assign rise      = $signed({1'b0, mv_ff}) - $signed({1'b0, last_mv_ff});

   always_comb begin
      charging_in   = charging_ff;
      warning_in    = warning_ff;
      peak_in       = peak_ff;
      started_in    = 1'b0;
      full_in       = 1'b0;
      warn_start_in = 1'b0;
      if (now_ff < {{(MS_BITS-IVL_BITS){1'b0}}, window_ff}) begin
         led_in = level_color(pct_ff);
      end else begin
         led_in = LED_NONE;
      end
      if (check_due) begin
         if (last_mv_ff != '0) begin
            if (rise > $signed({1'b0, delta_thr_ff})) begin
               charging_in = 1'b1;
               started_in  = 1'b1;
               warning_in  = 1'b0;
            end else if (charging_ff && (mv_ff >= full_mv_ff)) begin
               full_in = 1'b1;
               led_in  = LED_FULL;
               peak_in = mv_ff;
            end
         end
         if (mv_ff > peak_in) begin
            peak_in = mv_ff;
         end
      end
      if ((pct_ff < critical_ff) && !charging_in && !warning_in) begin
         warning_in    = 1'b1;
         warn_start_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         charging_ff <= 1'b0;
         warning_ff  <= 1'b0;
         last_ms_ff  <= '0;
         last_mv_ff  <= '0;
         peak_ff     <= '0;
      end else if (cmd.update) begin
         charging_ff <= charging_in;
         warning_ff  <= warning_in;
         peak_ff     <= peak_in;
         if (check_due) begin
            last_ms_ff <= now_ff;
            last_mv_ff <= mv_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.update) begin
         led_ff        <= led_in;
         started_ff    <= started_in;
         full_ff       <= full_in;
         warn_start_ff <= warn_start_in;
      end
   end

   assign battery_percent  = pct_ff;
   assign sample_mv        = mv_ff;
   assign led_code         = led_ff;
   assign charging         = charging_ff;
   assign charging_started = started_ff;
   assign full_charge      = full_ff;
   assign warning_active   = warning_ff;
   assign warning_started  = warn_start_ff;
   assign peak_mv          = peak_ff;

endmodule
